// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL controller of the n-body integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define NBGI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define NBGI_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/nbgi_pkg.sv -----
// Package of the n-body integrator: item types, codes, states and command types.
`timescale 1ns / 1ps

package nbgi_pkg;

  // Width of the body index that leaves the block.
  localparam int unsigned IDX_W = 6;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_GRAVITY     = 1'b0;
  localparam logic CFG_MIN_DIST_SQ = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        mass;
    logic [31:0]        dt;
  } nbgi_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   body_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic               status;
    logic               is_last;
  } nbgi_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_REJECT,
    ST_CUR_RD,
    ST_CUR_LAT,
    ST_J_SEL,
    ST_DIFF,
    ST_SQUARE,
    ST_SUM,
    ST_CHECK,
    ST_SQRT,
    ST_DIV_ACC,
    ST_SCALE,
    ST_UDIV_GO,
    ST_UDIV_WAIT,
    ST_DV,
    ST_VEL,
    ST_MOVE_MUL,
    ST_MOVE_UPD,
    ST_WRITE_BACK,
    ST_EM_RD,
    ST_EM_PUT
  } ctrl_state_e;

  typedef struct packed {
    logic             mem_we;
    logic             mem_we_mass;
    logic             wsrc_in;
    logic             mem_re;
    logic [IDX_W-1:0] addr;
    logic             in_lat;
    logic             cur_lat;
    logic             pair_diff;
    logic             pair_square;
    logic             pair_sum;
    logic             gm_calc;
    logic             sqrt_start;
    logic             div_start;
    logic             div_u;
    logic             s_calc;
    logic             dv_calc;
    logic             vel_upd;
    logic             move_mul;
    logic             move_upd;
    logic [1:0]       comp;
    logic             out_body;
    logic             out_reject;
    logic             out_last;
    logic [IDX_W-1:0] out_index;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic near;
    logic sqrt_done;
    logic div_done;
  } dp_sts_t;

endpackage

// ----- rtl/core/nbody_gravity_integrator_top.sv -----
// Top level of the n-body integrator: controller, datapath and ports.
// A load is written to the store, read back (ST_EM_RD) and put into the output register
// (ST_EM_PUT); a rejected load's report is put there from ST_REJECT. A step handles body
// after body; each pair that acts takes the root and the four divisions. After the step,
// reports leave body by body from the store read port, each once the output is free.
// Reset clears the controller and the output valid flag and presets the cfg registers;
// the body stores are not cleared and only entries that have been loaded are read.
`timescale 1ns / 1ps

module nbody_gravity_integrator_top #(
  parameter int unsigned MAX_BODIES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nbgi_pkg::nbgi_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nbgi_pkg::nbgi_out_t out_item_o
);

  // The controller owns the counters and the sequence; the datapath owns the
  // stores, the shared root and divider units and the output register. An item
  // is taken only while the controller is idle, and each result item waits in
  // the output register until the far side takes it.
  nbgi_pkg::dp_cmd_t cmd;
  nbgi_pkg::dp_sts_t sts;

  nbgi_ctrl #(
    .MAX_BODIES (MAX_BODIES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_item_i.req_type),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Positions of earlier bodies are written back before the next body reads
  // them, so each body sees the moved positions of those before it.
  nbgi_datapath #(
    .MAX_BODIES (MAX_BODIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/core/nbgi_div.sv -----
// Restoring divider of 64 by 64 bits, one quotient bit per cycle.
`timescale 1ns / 1ps

module nbgi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  localparam logic [6:0] DIV_STEPS = 7'd64;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [64:0] rem_q;
  logic [63:0] num_q, den_q, quo_q;
  logic [64:0] rem_sh, rem_n;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q[63:0], num_q[63]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_n  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_STEPS;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_n;
      num_q <= {num_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/core/nbgi_sqrt.sv -----
// Floor square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps

module nbgi_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [63:0] x_q, res_q, bit_q;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= rad_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// ----- rtl/core/nbgi_datapath.sv -----
// Datapath of the n-body integrator: body stores, pair arithmetic and output register.
`timescale 1ns / 1ps

module nbgi_datapath #(
  parameter int unsigned MAX_BODIES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  nbgi_pkg::nbgi_in_t in_item_i,
  input  nbgi_pkg::dp_cmd_t  cmd_i,
  output nbgi_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nbgi_pkg::nbgi_out_t out_item_o
);

  localparam int unsigned IW = $clog2(MAX_BODIES);

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > 50'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -50'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  logic [2:0][31:0] mem_pos [MAX_BODIES];
  logic [2:0][31:0] mem_vel [MAX_BODIES];
  logic [31:0]      mem_mass [MAX_BODIES];

  logic [IW-1:0]    addr;
  logic [2:0][31:0] wr_pos, wr_vel;
  logic [2:0][31:0] rd_pos_q, rd_vel_q;
  logic [31:0]      rd_mass_q;

  logic [31:0] gravity_q, min_dist_sq_q, dt_q;

  logic [2:0][31:0] cur_pos_q, cur_pos_d, cur_vel_q, cur_vel_d;
  logic [2:0]       neg_q;
  logic [2:0][32:0] mag_q;
  logic [2:0][63:0] sq_q;
  logic [63:0]      s4_q, gm_q;
  logic [31:0]      mass_j_q;
  logic [33:0]      s_q;
  logic [34:0]      dv_q;
  logic [2:0][47:0] pm_q;

  logic [2:0][32:0] diff, magd;
  logic [65:0]      sq_full [3];
  logic [63:0]      s4_sum;
  logic [49:0]      d2;
  logic [63:0]      gm_full, s_full;
  logic [31:0]      acc;
  logic [47:0]      s_sh;
  logic [33:0]      s_d;
  logic [16:0]      u_val;
  logic [50:0]      dv_full;
  logic [2:0][31:0] vmag;
  logic [63:0]      pm_full [3];
  logic signed [49:0] v_ext, dv_ext, p_ext, pm_ext;

  logic [63:0] div_num, div_den, div_quot;
  logic        div_done, sqrt_done;
  logic [31:0] root;

  logic                out_valid_q;
  nbgi_pkg::nbgi_out_t out_q;
  logic                out_free;

  assign addr   = cmd_i.addr[IW-1:0];
  assign wr_pos = cmd_i.wsrc_in ?
                  {in_item_i.pos_z, in_item_i.pos_y, in_item_i.pos_x} : cur_pos_q;
  assign wr_vel = cmd_i.wsrc_in ?
                  {in_item_i.vel_z, in_item_i.vel_y, in_item_i.vel_x} : cur_vel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_pos[addr] <= wr_pos;
      mem_vel[addr] <= wr_vel;
    end
    if (cmd_i.mem_we_mass) begin
      mem_mass[addr] <= in_item_i.mass;
    end
    if (cmd_i.mem_re) begin
      rd_pos_q  <= mem_pos[addr];
      rd_vel_q  <= mem_vel[addr];
      rd_mass_q <= mem_mass[addr];
    end
  end

  // Pair and move arithmetic; each product lands in a register.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c]    = {cur_pos_q[c][31], cur_pos_q[c]} - {rd_pos_q[c][31], rd_pos_q[c]};
      magd[c]    = diff[c][32] ? (~diff[c] + 33'd1) : diff[c];
      sq_full[c] = 66'(mag_q[c]) * 66'(mag_q[c]);
      vmag[c]    = cur_vel_q[c][31] ? (~cur_vel_q[c] + 32'd1) : cur_vel_q[c];
      pm_full[c] = 64'(vmag[c]) * 64'(dt_q);
    end
    s4_sum  = (sq_q[0] >> 2) + (sq_q[1] >> 2) + (sq_q[2] >> 2);
    d2      = s4_q[63:14];
    gm_full = 64'(gravity_q) * 64'(mass_j_q);
    acc     = (div_quot > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : div_quot[31:0];
    s_full  = 64'(acc) * 64'(dt_q);
    s_sh    = s_full[63:16];
    s_d     = (s_sh > 48'h2_0000_0000) ? 34'h2_0000_0000 : s_sh[33:0];
    u_val   = (div_quot > 64'd65536) ? 17'h10000 : div_quot[16:0];
    dv_full = 51'(s_q) * 51'(u_val);
    div_num = cmd_i.div_u ? {15'b0, mag_q[cmd_i.comp], 16'b0} : gm_q;
    div_den = cmd_i.div_u ? {31'b0, root, 1'b0} : {14'b0, d2};
  end

  always_comb begin
    cur_pos_d = cur_pos_q;
    cur_vel_d = cur_vel_q;
    v_ext     = 50'(signed'(cur_vel_q[cmd_i.comp]));
    dv_ext    = signed'({15'b0, dv_q});
    if (cmd_i.cur_lat) begin
      cur_pos_d = rd_pos_q;
      cur_vel_d = rd_vel_q;
    end
    if (cmd_i.vel_upd) begin
      // The kick points from body i towards body j.
      cur_vel_d[cmd_i.comp] = neg_q[cmd_i.comp] ? sat32(v_ext + dv_ext) : sat32(v_ext - dv_ext);
    end
    if (cmd_i.move_upd) begin
      for (int c = 0; c < 3; c++) begin
        p_ext  = 50'(signed'(cur_pos_q[c]));
        pm_ext = signed'({2'b0, pm_q[c]});
        cur_pos_d[c] = cur_vel_q[c][31] ? sat32(p_ext - pm_ext) : sat32(p_ext + pm_ext);
      end
    end else begin
      p_ext  = '0;
      pm_ext = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pos_q <= cur_pos_d;
    cur_vel_q <= cur_vel_d;
    if (cmd_i.in_lat) dt_q <= in_item_i.dt;
    if (cmd_i.pair_diff) begin
      for (int c = 0; c < 3; c++) begin
        neg_q[c] <= diff[c][32];
        mag_q[c] <= magd[c];
      end
      mass_j_q <= rd_mass_q;
    end
    if (cmd_i.pair_square) begin
      for (int c = 0; c < 3; c++) sq_q[c] <= sq_full[c][63:0];
    end
    if (cmd_i.pair_sum) s4_q <= s4_sum;
    if (cmd_i.gm_calc)  gm_q <= gm_full;
    if (cmd_i.s_calc)   s_q  <= s_d;
    if (cmd_i.dv_calc)  dv_q <= dv_full[50:16];
    if (cmd_i.move_mul) begin
      for (int c = 0; c < 3; c++) pm_q[c] <= pm_full[c][63:16];
    end
  end

  nbgi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (s4_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  nbgi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q     <= 32'h0001_0000;
      min_dist_sq_q <= 32'h0000_0001;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          nbgi_pkg::CFG_GRAVITY:     gravity_q     <= cfg_data_i;
          nbgi_pkg::CFG_MIN_DIST_SQ: min_dist_sq_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.out_body || cmd_i.out_reject) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_body) begin
      out_q.body_index <= cmd_i.out_index;
      out_q.out_pos_x  <= rd_pos_q[0];
      out_q.out_pos_y  <= rd_pos_q[1];
      out_q.out_pos_z  <= rd_pos_q[2];
      out_q.out_vel_x  <= rd_vel_q[0];
      out_q.out_vel_y  <= rd_vel_q[1];
      out_q.out_vel_z  <= rd_vel_q[2];
      out_q.status     <= 1'b0;
      out_q.is_last    <= cmd_i.out_last;
    end else if (cmd_i.out_reject) begin
      out_q <= '{status: 1'b1, is_last: 1'b1, default: '0};
    end
  end

  assign out_free        = !out_valid_q || !out_stall_i;
  assign sts_o.out_free  = out_free;
  assign sts_o.near      = d2 <= {18'b0, min_dist_sq_q};
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = div_done;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

endmodule

// ----- rtl/core/nbgi_ctrl.sv -----
// Controller of the n-body integrator: sequences loads, pair kicks, moves and reports.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nbgi_ctrl #(
  parameter int unsigned MAX_BODIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_type_i,
  output logic              in_stall_o,
  input  nbgi_pkg::dp_sts_t sts_i,
  output nbgi_pkg::dp_cmd_t cmd_o
);

  localparam int unsigned IW = $clog2(MAX_BODIES);
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BODIES);

  nbgi_pkg::ctrl_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, j_q, j_d;
  logic [IW-1:0] i_q, i_d, k_q, k_d;
  logic [1:0]    c_q, c_d;
  logic          em_load_q, em_load_d;
  logic          i_last, k_last;

  assign i_last = (CW'(i_q) + CW'(1)) == count_q;
  assign k_last = em_load_q || ((CW'(k_q) + CW'(1)) == count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    c_d       = c_q;
    em_load_d = em_load_q;
    case (state_q)
      nbgi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_type_i == nbgi_pkg::REQ_LOAD) begin
            if (count_q >= MAX_CNT) begin
              state_d = nbgi_pkg::ST_REJECT;
            end else begin
              k_d       = count_q[IW-1:0];
              em_load_d = 1'b1;
              count_d   = count_q + CW'(1);
              state_d   = nbgi_pkg::ST_EM_RD;
            end
          end else if (count_q != '0) begin
            i_d     = '0;
            state_d = nbgi_pkg::ST_CUR_RD;
          end
        end
      end
      nbgi_pkg::ST_REJECT: if (sts_i.out_free) state_d = nbgi_pkg::ST_IDLE;
      nbgi_pkg::ST_CUR_RD: state_d = nbgi_pkg::ST_CUR_LAT;
      nbgi_pkg::ST_CUR_LAT: begin
        j_d     = '0;
        state_d = nbgi_pkg::ST_J_SEL;
      end
      nbgi_pkg::ST_J_SEL: begin
        if (j_q == count_q) state_d = nbgi_pkg::ST_MOVE_MUL;
        else if (j_q == CW'(i_q)) j_d = j_q + CW'(1);
        else state_d = nbgi_pkg::ST_DIFF;
      end
      nbgi_pkg::ST_DIFF:   state_d = nbgi_pkg::ST_SQUARE;
      nbgi_pkg::ST_SQUARE: state_d = nbgi_pkg::ST_SUM;
      nbgi_pkg::ST_SUM:    state_d = nbgi_pkg::ST_CHECK;
      nbgi_pkg::ST_CHECK: begin
        if (sts_i.near) begin
          j_d     = j_q + CW'(1);
          state_d = nbgi_pkg::ST_J_SEL;
        end else begin
          state_d = nbgi_pkg::ST_SQRT;
        end
      end
      nbgi_pkg::ST_SQRT:    if (sts_i.sqrt_done) state_d = nbgi_pkg::ST_DIV_ACC;
      nbgi_pkg::ST_DIV_ACC: if (sts_i.div_done) state_d = nbgi_pkg::ST_SCALE;
      nbgi_pkg::ST_SCALE: begin
        c_d     = 2'd0;
        state_d = nbgi_pkg::ST_UDIV_GO;
      end
      nbgi_pkg::ST_UDIV_GO:   state_d = nbgi_pkg::ST_UDIV_WAIT;
      nbgi_pkg::ST_UDIV_WAIT: if (sts_i.div_done) state_d = nbgi_pkg::ST_DV;
      nbgi_pkg::ST_DV:        state_d = nbgi_pkg::ST_VEL;
      nbgi_pkg::ST_VEL: begin
        if (c_q == 2'd2) begin
          j_d     = j_q + CW'(1);
          state_d = nbgi_pkg::ST_J_SEL;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = nbgi_pkg::ST_UDIV_GO;
        end
      end
      nbgi_pkg::ST_MOVE_MUL: state_d = nbgi_pkg::ST_MOVE_UPD;
      nbgi_pkg::ST_MOVE_UPD: state_d = nbgi_pkg::ST_WRITE_BACK;
      nbgi_pkg::ST_WRITE_BACK: begin
        if (i_last) begin
          k_d       = '0;
          em_load_d = 1'b0;
          state_d   = nbgi_pkg::ST_EM_RD;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = nbgi_pkg::ST_CUR_RD;
        end
      end
      nbgi_pkg::ST_EM_RD: state_d = nbgi_pkg::ST_EM_PUT;
      nbgi_pkg::ST_EM_PUT: begin
        if (sts_i.out_free) begin
          if (k_last) begin
            state_d = nbgi_pkg::ST_IDLE;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = nbgi_pkg::ST_EM_RD;
          end
        end
      end
      default: state_d = nbgi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.comp = c_q;
    case (state_q)
      nbgi_pkg::ST_IDLE: begin
        cmd_o.addr = nbgi_pkg::IDX_W'(count_q);
        if (in_valid_i) begin
          cmd_o.in_lat = 1'b1;
          if (in_req_type_i == nbgi_pkg::REQ_LOAD && count_q < MAX_CNT) begin
            cmd_o.mem_we      = 1'b1;
            cmd_o.mem_we_mass = 1'b1;
            cmd_o.wsrc_in     = 1'b1;
          end
        end
      end
      nbgi_pkg::ST_REJECT: cmd_o.out_reject = sts_i.out_free;
      nbgi_pkg::ST_CUR_RD: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.addr   = nbgi_pkg::IDX_W'(i_q);
      end
      nbgi_pkg::ST_CUR_LAT: cmd_o.cur_lat = 1'b1;
      nbgi_pkg::ST_J_SEL: begin
        cmd_o.addr   = nbgi_pkg::IDX_W'(j_q);
        cmd_o.mem_re = (j_q != count_q) && (j_q != CW'(i_q));
      end
      nbgi_pkg::ST_DIFF:   cmd_o.pair_diff   = 1'b1;
      nbgi_pkg::ST_SQUARE: cmd_o.pair_square = 1'b1;
      nbgi_pkg::ST_SUM:    cmd_o.pair_sum    = 1'b1;
      nbgi_pkg::ST_CHECK: begin
        cmd_o.gm_calc    = !sts_i.near;
        cmd_o.sqrt_start = !sts_i.near;
      end
      nbgi_pkg::ST_SQRT:    cmd_o.div_start = sts_i.sqrt_done;
      nbgi_pkg::ST_DIV_ACC: ;
      nbgi_pkg::ST_SCALE:   cmd_o.s_calc = 1'b1;
      nbgi_pkg::ST_UDIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_u     = 1'b1;
      end
      nbgi_pkg::ST_UDIV_WAIT: ;
      nbgi_pkg::ST_DV:        cmd_o.dv_calc  = 1'b1;
      nbgi_pkg::ST_VEL:       cmd_o.vel_upd  = 1'b1;
      nbgi_pkg::ST_MOVE_MUL:  cmd_o.move_mul = 1'b1;
      nbgi_pkg::ST_MOVE_UPD:  cmd_o.move_upd = 1'b1;
      nbgi_pkg::ST_WRITE_BACK: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.addr   = nbgi_pkg::IDX_W'(i_q);
      end
      nbgi_pkg::ST_EM_RD: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.addr   = nbgi_pkg::IDX_W'(k_q);
      end
      nbgi_pkg::ST_EM_PUT: begin
        cmd_o.out_body  = sts_i.out_free;
        cmd_o.out_last  = k_last;
        cmd_o.out_index = nbgi_pkg::IDX_W'(k_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nbgi_pkg::ST_IDLE;
      count_q   <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      c_q       <= 2'd0;
      em_load_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      c_q       <= c_d;
      em_load_q <= em_load_d;
    end
  end

  assign in_stall_o = state_q != nbgi_pkg::ST_IDLE;

  `NBGI_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= MAX_CNT, "body count above table size")
  `NBGI_ASSERT(a_push_free, clk_i, rst_ni, !(cmd_o.out_body || cmd_o.out_reject) || sts_i.out_free, "result pushed into a full output register")
  `NBGI_ASSERT(a_body_in_table, clk_i, rst_ni, state_q != nbgi_pkg::ST_CUR_RD || CW'(i_q) < count_q, "body index outside the table")
  `NBGI_ASSERT_NEXT(a_div_after_sqrt, clk_i, rst_ni, state_q == nbgi_pkg::ST_SQRT && sts_i.sqrt_done, state_q == nbgi_pkg::ST_DIV_ACC && !sts_i.div_done, "divider not started after the root")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the n-body integrator: directed table, random phases, then a full table.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NB = 32;
  localparam bit [63:0] M32 = 64'hFFFF_FFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = nbgi_pkg::CFG_GRAVITY;
  logic [31:0]         cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  nbgi_pkg::nbgi_in_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  nbgi_pkg::nbgi_out_t out_item_o;

  nbody_gravity_integrator_top #(.MAX_BODIES(NB)) u_top (.*);

  // The clock runs at a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The predictor keeps its own copy of the body table and of the two registers.
  longint    body_pos [3][NB];
  longint    body_vel [3][NB];
  bit [31:0] body_mass [NB];
  int        body_count;
  bit [31:0] grav_q;
  bit [31:0] min_d2_q;

  // Reports still owed by the block, oldest first.
  nbgi_pkg::nbgi_out_t pending_reports [$];
  int        errors;
  int        idle_pct;
  int        stall_pct;

  function automatic void owe_report(nbgi_pkg::nbgi_out_t r);
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] r;
    bit [63:0] b;
    r = '0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Velocity kick on body i from body j; pairs at or under the threshold do nothing.
  function automatic void gravity_kick(int i, int j, bit [63:0] dt);
    longint    d [3];
    bit [63:0] m, s4, d2, span, acc, s, u, dvm;
    s4 = '0;
    for (int c = 0; c < 3; c++) begin
      d[c] = body_pos[c][i] - body_pos[c][j];
      m = mag(d[c]);
      s4 += (m * m) >> 2;
    end
    d2 = s4 >> 14;
    if (d2 <= 64'(min_d2_q)) return;
    span = floor_sqrt(s4) << 1;
    acc = (64'(grav_q) * 64'(body_mass[j])) / d2;
    if (acc > M32) acc = M32;
    s = (acc * dt) >> 16;
    if (s > (64'h1 << 33)) s = 64'h1 << 33;
    for (int c = 0; c < 3; c++) begin
      u = (mag(d[c]) << 16) / span;
      if (u > 64'd65536) u = 64'd65536;
      dvm = (s * u) >> 16;
      if (d[c] < 0) body_vel[c][i] = sat32(body_vel[c][i] + longint'(dvm));
      else body_vel[c][i] = sat32(body_vel[c][i] - longint'(dvm));
    end
  endfunction

  function automatic nbgi_pkg::nbgi_out_t body_report(int idx, bit last);
    nbgi_pkg::nbgi_out_t r;
    r.body_index = idx[nbgi_pkg::IDX_W-1:0];
    r.out_pos_x  = body_pos[0][idx][31:0];
    r.out_pos_y  = body_pos[1][idx][31:0];
    r.out_pos_z  = body_pos[2][idx][31:0];
    r.out_vel_x  = body_vel[0][idx][31:0];
    r.out_vel_y  = body_vel[1][idx][31:0];
    r.out_vel_z  = body_vel[2][idx][31:0];
    r.status     = 1'b0;
    r.is_last    = last;
    return r;
  endfunction

  // Works out the reports that one accepted item causes and queues them.
  function automatic void predict_reports(nbgi_pkg::nbgi_in_t it);
    nbgi_pkg::nbgi_out_t rej;
    bit [63:0] dt;
    bit [63:0] pm;
    if (it.req_type == nbgi_pkg::REQ_LOAD) begin
      if (body_count >= NB) begin
        rej = '0;
        rej.status = 1'b1;
        rej.is_last = 1'b1;
        owe_report(rej);
        return;
      end
      body_pos[0][body_count] = longint'(it.pos_x);
      body_pos[1][body_count] = longint'(it.pos_y);
      body_pos[2][body_count] = longint'(it.pos_z);
      body_vel[0][body_count] = longint'(it.vel_x);
      body_vel[1][body_count] = longint'(it.vel_y);
      body_vel[2][body_count] = longint'(it.vel_z);
      body_mass[body_count] = it.mass;
      body_count++;
      owe_report(body_report(body_count - 1, 1'b1));
      return;
    end
    dt = 64'(it.dt);
    for (int i = 0; i < body_count; i++) begin
      for (int j = 0; j < body_count; j++) begin
        if (j != i) gravity_kick(i, j, dt);
      end
      for (int c = 0; c < 3; c++) begin
        pm = (mag(body_vel[c][i]) * dt) >> 16;
        if (body_vel[c][i] < 0) body_pos[c][i] = sat32(body_pos[c][i] - longint'(pm));
        else body_pos[c][i] = sat32(body_pos[c][i] + longint'(pm));
      end
    end
    for (int i = 0; i < body_count; i++) begin
      owe_report(body_report(i, i == body_count - 1));
    end
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Reports are compared at the rising edge at which they are taken.
  always @(posedge clk_i) begin
    nbgi_pkg::nbgi_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("report for body %0d arrived with none expected", out_item_o.body_index);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("body_index", want.body_index, out_item_o.body_index);
        check_field("out_pos_x", want.out_pos_x, out_item_o.out_pos_x);
        check_field("out_pos_y", want.out_pos_y, out_item_o.out_pos_y);
        check_field("out_pos_z", want.out_pos_z, out_item_o.out_pos_z);
        check_field("out_vel_x", want.out_vel_x, out_item_o.out_vel_x);
        check_field("out_vel_y", want.out_vel_y, out_item_o.out_vel_y);
        check_field("out_vel_z", want.out_vel_z, out_item_o.out_vel_z);
        check_field("status", want.status, out_item_o.status);
        check_field("is_last", want.is_last, out_item_o.is_last);
      end
    end
  end

  // The receiver stalls at random, changing only at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Presents one item with random gaps before it and waits until it is taken.
  task automatic send_item(nbgi_pkg::nbgi_in_t it);
    logic [287:0] noise;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      in_item_i = noise[256:0];
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_reports(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Waits until every owed report has come, then lets the block settle.
  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == nbgi_pkg::CFG_GRAVITY) grav_q = value;
    else min_d2_q = value;
  endtask

  function automatic nbgi_pkg::nbgi_in_t load_item(logic [31:0] px, logic [31:0] py,
                                                   logic [31:0] pz, logic [31:0] vx,
                                                   logic [31:0] vy, logic [31:0] vz,
                                                   logic [31:0] m);
    nbgi_pkg::nbgi_in_t it;
    it = '{nbgi_pkg::REQ_LOAD, px, py, pz, vx, vy, vz, m, $urandom};
    return it;
  endfunction

  function automatic nbgi_pkg::nbgi_in_t step_item(logic [31:0] dt);
    nbgi_pkg::nbgi_in_t it;
    it = '{nbgi_pkg::REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, dt};
    return it;
  endfunction

  // Mostly a compact cluster so that pairs act; now and then any 32-bit value.
  function automatic nbgi_pkg::nbgi_in_t random_load();
    logic [31:0] f [7];
    bit          wide;
    wide = ($urandom_range(7) == 0);
    for (int k = 0; k < 3; k++) f[k] = wide ? $urandom : $urandom_range(32'h0080_0000) - 32'h0040_0000;
    for (int k = 3; k < 6; k++) f[k] = wide ? $urandom : $urandom_range(32'h0004_0000) - 32'h0002_0000;
    f[6] = wide ? $urandom : $urandom_range(32'h0004_0000);
    return load_item(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
  endfunction

  function automatic nbgi_pkg::nbgi_in_t random_step();
    return step_item(($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h0000_4000));
  endfunction

  // One random phase: mostly loads while the table holds under load_cap bodies, otherwise steps.
  task automatic random_phase(int n_items, int load_cap, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < n_items; k++) begin
      // Halfway through, the sender holds off until the block has answered everything.
      if (k == n_items / 2) wait_drained();
      if (body_count < load_cap && $urandom_range(2) != 0) send_item(random_load());
      else send_item(random_step());
    end
  endtask

  typedef struct {
    nbgi_pkg::nbgi_in_t  item;
    bit                  typed;
    nbgi_pkg::nbgi_out_t want;
  } stim_row_t;

  stim_row_t rows [$];

  function automatic void add_row(nbgi_pkg::nbgi_in_t it, bit typed,
                                  nbgi_pkg::nbgi_out_t want);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    rows.insert(rows.size(), row);
  endfunction

  initial begin
    stim_row_t row;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    body_count = 0;
    grav_q = 32'h0001_0000;
    min_d2_q = 32'd1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. A step on an empty table answers nothing.
    add_row(step_item(32'h0001_0000), 1'b0, '0);
    // Loads at the field extremes echo the stored body back at once.
    add_row(load_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF), 1'b1,
            '{6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1});
    add_row(load_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0), 1'b1,
            '{6'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1});
    add_row(load_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000), 1'b1,
            '{6'd2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1});
    // A second body on the same spot: that pair sits under the threshold.
    add_row(load_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000), 1'b1,
            '{6'd3, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1});
    add_row(load_item(32'hAAAA_5555, 32'h5555_AAAA, 32'h0003_0000, 32'hFFFF_0000,
                      32'h0000_FFFF, 32'h0001_8000, 32'h0002_0000), 1'b1,
            '{6'd4, 32'hAAAA_5555, 32'h5555_AAAA, 32'h0003_0000, 32'hFFFF_0000,
              32'h0000_FFFF, 32'h0001_8000, 1'b0, 1'b1});
    add_row(step_item(32'h0), 1'b0, '0);
    add_row(step_item(32'hFFFF_FFFF), 1'b0, '0);
    add_row(step_item(32'h0001_0000), 1'b0, '0);
    add_row(step_item(32'h0000_8000), 1'b0, '0);
    foreach (rows[r]) begin
      row = rows[r];
      send_item(row.item);
      if (row.typed) begin
        pending_reports[pending_reports.size() - 1] = row.want;
      end
    end
    wait_drained();

    // Random phases, each under its own register setting and idling pattern.
    random_phase(45, 7, 0, 0);
    wait_drained();
    write_reg(nbgi_pkg::CFG_GRAVITY, 32'hFFFF_FFFF);
    write_reg(nbgi_pkg::CFG_MIN_DIST_SQ, 32'h0);
    random_phase(45, 7, 48, 0);
    wait_drained();
    write_reg(nbgi_pkg::CFG_GRAVITY, 32'h0);
    write_reg(nbgi_pkg::CFG_MIN_DIST_SQ, 32'hFFFF_FFFF);
    random_phase(40, 7, 0, 48);
    wait_drained();
    write_reg(nbgi_pkg::CFG_GRAVITY, $urandom);
    write_reg(nbgi_pkg::CFG_MIN_DIST_SQ, $urandom_range(32'h0010_0000));
    random_phase(40, 7, 15, 15);
    wait_drained();

    // Fill the table, overrun it so that loads are refused, step the full set, refuse a load, step again.
    write_reg(nbgi_pkg::CFG_GRAVITY, 32'h0001_0000);
    write_reg(nbgi_pkg::CFG_MIN_DIST_SQ, 32'h0001_0000);
    idle_pct = 15;
    stall_pct = 15;
    while (body_count < NB) send_item(random_load());
    repeat (3) send_item(random_load());
    send_item(random_step());
    send_item(random_load());
    send_item(random_step());

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/nbgi_pkg.sv
rtl/core/nbgi_div.sv
rtl/core/nbgi_sqrt.sv
rtl/core/nbgi_datapath.sv
rtl/core/nbgi_ctrl.sv
rtl/core/nbody_gravity_integrator_top.sv
sim/tb.sv
